[hw/rtl/kmd_pkg.sv]
// kmd_pkg: constants, register codes and shared types of the key matrix debounce block
// no dependencies; imported by the interfaces and every module of the block
package kmd_pkg;

   // matrix geometry
   localparam int NUM_ROWS   = 4;
   localparam int NUM_COLS   = 4;
   localparam int NUM_KEYS   = NUM_ROWS * NUM_COLS;
   localparam int IN_COLS    = 4;
   localparam int LANES      = (NUM_COLS < IN_COLS) ? NUM_COLS : IN_COLS;
   localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int ROW_IDX_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   // field widths
   localparam int ROW_W      = 2;
   localparam int TIME_W     = 32;
   localparam int DEBOUNCE_W = 8;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int CHAN_W     = 5;
   localparam int SUM_W      = ((KEY_W > NOTE_W) ? KEY_W : NOTE_W) + 1;
   localparam int NOTE_MAX   = 127;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TIME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NOTE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_VELOCITY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDI_CHANNEL   = 2'd3;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd5;
   localparam logic [NOTE_W-1:0]     BASE_RESET     = 7'd36;
   localparam logic [VEL_W-1:0]      VEL_RESET      = 7'd100;
   localparam logic [CHAN_W-1:0]     CHAN_RESET     = 5'd1;

   // what one lane found for the scanned key
   typedef struct packed {
      logic fire;   // debounced level changed
      logic level;  // new debounced level
   } kmd_event_type;

endpackage

[hw/rtl/kmd_if.sv]
// kmd_if: valid/ready channel interfaces for scanned rows and note events
// depends on kmd_pkg for the field widths
interface kmd_req_if import kmd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  row;
   logic [IN_COLS-1:0] col_pressed;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, row, col_pressed, now_ms, input ready);
   modport sink   (input valid, row, col_pressed, now_ms, output ready);
endinterface

interface kmd_rsp_if import kmd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NOTE_W-1:0] note;
   logic              note_on;
   logic [VEL_W-1:0]  velocity;
   logic [CHAN_W-1:0] channel;
   logic              last;

   modport source (output valid, note, note_on, velocity, channel, last, input ready);
   modport sink   (input valid, note, note_on, velocity, channel, last, output ready);
endinterface

[hw/rtl/kmd_lane.sv]
// kmd_lane: debounce state of one matrix column, one entry per row
// depends on kmd_pkg; one instance per scanned column in the top level
module kmd_lane import kmd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  scan,
   input  logic [ROW_IDX_W-1:0]  row_idx,
   input  logic                  raw,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic [DEBOUNCE_W-1:0] hold_ms,
   output kmd_event_type         evt
);

   logic              stable_ff [NUM_ROWS];
   logic              raw_ff    [NUM_ROWS];
   logic [TIME_W-1:0] time_ff   [NUM_ROWS];

   logic [TIME_W-1:0] held;
   logic              changed;

   // time the raw level has held, modulo 2^32
   always_comb begin
      changed   = (raw != raw_ff[row_idx]);
      held      = now_ms - time_ff[row_idx];
      evt.level = raw;
      evt.fire  = !changed && (raw != stable_ff[row_idx]) &&
                  (held >= TIME_W'(hold_ms));
   end

   // per key state update on a scan of this row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            stable_ff[r] <= 1'b0;
            raw_ff[r]    <= 1'b0;
            time_ff[r]   <= '0;
         end
      end else if (scan) begin
         if (changed) begin
            raw_ff[row_idx]  <= raw;
            time_ff[row_idx] <= now_ms;
         end else if (evt.fire) begin
            stable_ff[row_idx] <= raw;
         end
      end
   end

endmodule

[hw/rtl/kmd_merge.sv]
// kmd_merge: collects the lane events of one row and sends them in column order
// depends on kmd_pkg and kmd_rsp_if; fed by the kmd_lane instances
module kmd_merge import kmd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [ROW_W-1:0]     row,
   input  kmd_event_type        evt [LANES],
   input  logic [NOTE_W-1:0]    base_note,
   input  logic [VEL_W-1:0]     press_velocity,
   input  logic [CHAN_W-1:0]    midi_channel,
   output logic                 take_row,
   kmd_rsp_if.source            rsp
);

   logic [LANES-1:0]  pend_ff, pend_in;
   logic [LANES-1:0]  level_ff, level_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic              out_valid_ff, out_valid_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic              on_ff, on_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              emit;
   logic [LANES-1:0]  sel;
   logic [LANE_W-1:0] sel_col;
   logic [LANES-1:0]  remain;
   logic [KEY_W-1:0]  key;
   logic [SUM_W-1:0]  sum;

   // lowest pending column goes out first
   always_comb begin
      sel     = '0;
      sel_col = '0;
      for (int c = LANES - 1; c >= 0; c--) begin
         if (pend_ff[c]) begin
            sel     = '0;
            sel[c]  = 1'b1;
            sel_col = LANE_W'(c);
         end
      end
      remain   = pend_ff & ~sel;
      out_free = !out_valid_ff || rsp.ready;
      emit     = (pend_ff != '0) && out_free;
      // a new row fits once the buffered one is down to its final event
      take_row = (pend_ff == '0) || (remain == '0 && out_free);
   end

   // note number of the selected key, before saturation
   always_comb begin
      key = KEY_W'(KEY_W'(row_ff) * KEY_W'(NUM_COLS) + KEY_W'(sel_col));
      sum = SUM_W'(base_note) + SUM_W'(key);
   end

   // next state of the event buffer and the output register
   always_comb begin
      pend_in      = emit ? remain : pend_ff;
      level_in     = level_ff;
      row_in       = row_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      note_in      = note_ff;
      on_in        = on_ff;
      vel_in       = vel_ff;
      chan_in      = chan_ff;
      last_in      = last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         note_in      = (sum > SUM_W'(NOTE_MAX)) ? NOTE_W'(NOTE_MAX) : NOTE_W'(sum);
         on_in        = |(level_ff & sel);
         vel_in       = (|(level_ff & sel)) ? press_velocity : '0;
         chan_in      = midi_channel;
         last_in      = (remain == '0);
      end
      if (load) begin
         for (int c = 0; c < LANES; c++) begin
            pend_in[c]  = evt[c].fire;
            level_in[c] = evt[c].level;
         end
         row_in = row;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      level_ff <= level_in;
      row_ff   <= row_in;
      note_ff  <= note_in;
      on_ff    <= on_in;
      vel_ff   <= vel_in;
      chan_ff  <= chan_in;
      last_ff  <= last_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.note     = note_ff;
   assign rsp.note_on  = on_ff;
   assign rsp.velocity = vel_ff;
   assign rsp.channel  = chan_ff;
   assign rsp.last     = last_ff;

endmodule

[hw/rtl/key_matrix_debounce_note_events.sv]
// Key matrix scanner with per-key debounce that turns confirmed key changes into note
// events. Each transfer on req carries one scanned row; one lane per column compares the
// raw bit against that key's stored state and timer, and a merge stage sends the
// confirmations of the row on rsp in ascending column order, the final one with last set.
// Rows are accepted every cycle while each confirms at most one key and rsp does not
// stall; the single output register, which sends one event per cycle while rsp is
// ready, sets the rate when a row confirms more. A row number at or above the row
// count is accepted and ignored. Configuration is written through csr_we, csr_index and
// csr_wdata; write only while no events are outstanding.
// depends on kmd_pkg, kmd_if, kmd_lane and kmd_merge
module key_matrix_debounce_note_events import kmd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   kmd_req_if.sink               req,
   kmd_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [NOTE_W-1:0]     base_ff;
   logic [VEL_W-1:0]      vel_ff;
   logic [CHAN_W-1:0]     chan_ff;

   logic                  take_row;
   logic                  row_ok;
   logic                  scan;
   kmd_event_type         evt [LANES];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         base_ff     <= BASE_RESET;
         vel_ff      <= VEL_RESET;
         chan_ff     <= CHAN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_TIME:  debounce_ff <= csr_wdata[DEBOUNCE_W-1:0];
            CSR_BASE_NOTE:      base_ff     <= csr_wdata[NOTE_W-1:0];
            CSR_PRESS_VELOCITY: vel_ff      <= csr_wdata[VEL_W-1:0];
            CSR_MIDI_CHANNEL:   chan_ff     <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // row transfer
   assign req.ready = take_row;
   assign row_ok    = (32'(req.row) < NUM_ROWS);
   assign scan      = req.valid && take_row && row_ok;

   // one debounce lane per column
   for (genvar c = 0; c < LANES; c++) begin : g_lane
      kmd_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .scan        (scan),
         .row_idx     (ROW_IDX_W'(req.row)),
         .raw         (req.col_pressed[c]),
         .now_ms      (req.now_ms),
         .hold_ms     (debounce_ff),
         .evt         (evt[c])
      );
   end

   // column ordered event output
   kmd_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (scan),
      .row            (req.row),
      .evt            (evt),
      .base_note      (base_ff),
      .press_velocity (vel_ff),
      .midi_channel   (chan_ff),
      .take_row       (take_row),
      .rsp            (rsp)
   );

endmodule

[tb/sv/tb_key_matrix_debounce_note_events.sv]
// tb_key_matrix_debounce_note_events: self-checking bench for the key matrix debounce block
// drives scanned rows, predicts debounced note events and checks each rsp transfer in order
// depends on kmd_pkg, kmd_if and key_matrix_debounce_note_events
`timescale 1ns / 1ps

module tb_key_matrix_debounce_note_events;
   import kmd_pkg::*;

   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [IN_COLS-1:0] cols;
      logic [TIME_W-1:0]  now;
   } row_scan_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic              note_on;
      logic [VEL_W-1:0]  velocity;
      logic [CHAN_W-1:0] channel;
      logic              last;
   } note_event_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kmd_req_if req_ch ();
   kmd_rsp_if rsp_ch ();

   key_matrix_debounce_note_events u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // rows waiting to be driven and note events waiting to arrive
   row_scan_type   scan_q[$];
   note_event_type note_q[$];

   // predictor copy of the registers
   logic [DEBOUNCE_W-1:0] cfg_debounce = DEBOUNCE_RESET;
   logic [NOTE_W-1:0]     cfg_base     = BASE_RESET;
   logic [VEL_W-1:0]      cfg_velocity = VEL_RESET;
   logic [CHAN_W-1:0]     cfg_channel  = CHAN_RESET;

   // predictor copy of the per-key state
   logic              key_stable [NUM_KEYS] = '{default: 1'b0};
   logic              key_raw    [NUM_KEYS] = '{default: 1'b0};
   logic [TIME_W-1:0] key_since  [NUM_KEYS] = '{default: '0};

   // idling and hold-off controls
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // stimulus generator state
   logic [TIME_W-1:0]  scan_now = '0;
   logic [ROW_W-1:0]   scan_row = '0;
   logic [IN_COLS-1:0] row_target [NUM_ROWS] = '{default: '0};

   // run statistics
   int err_count     = 0;
   int rows_taken    = 0;
   int events_seen   = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      if (err_count < MAX_REPORTS)
         $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("event %0d %s: got %0d, expected %0d",
                                   events_seen, name, got, want));
   endtask

   // debounce one scanned row and queue the note events it confirms
   function automatic void predict_row(logic [ROW_W-1:0] row, logic [IN_COLS-1:0] cols,
                                       logic [TIME_W-1:0] now);
      note_event_type    found [LANES];
      int                count;
      int                key;
      int                note_sum;
      logic              raw;
      logic [TIME_W-1:0] held;
      count = 0;
      if (row >= NUM_ROWS)
         return;
      for (int c = 0; c < LANES; c++) begin
         key = int'(row) * NUM_COLS + c;
         if (key >= NUM_KEYS)
            break;
         raw = cols[c];
         held = now - key_since[key];
         if (raw != key_raw[key]) begin
            key_raw[key] = raw;
            key_since[key] = now;
         end else if (raw != key_stable[key] && held >= TIME_W'(cfg_debounce)) begin
            key_stable[key] = raw;
            note_sum = int'(cfg_base) + key;
            if (note_sum > NOTE_MAX)
               note_sum = NOTE_MAX;
            found[count].note     = NOTE_W'(note_sum);
            found[count].note_on  = raw;
            found[count].velocity = raw ? cfg_velocity : '0;
            found[count].channel  = cfg_channel;
            found[count].last     = 1'b0;
            count++;
         end
      end
      if (count > 0)
         found[count-1].last = 1'b1;
      for (int i = 0; i < count; i++)
         note_q.push_back(found[i]);
   endfunction

   // row driver: holds each row until its transfer, idles at random
   always @(posedge clock) begin : req_driver
      row_scan_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (scan_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = scan_q.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.row         <= item.row;
            req_ch.col_pressed <= item.cols;
            req_ch.now_ms      <= item.now;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // event receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // row transfers feed the predictor
   always @(posedge clock) begin : row_monitor
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_row(req_ch.row, req_ch.col_pressed, req_ch.now_ms);
         rows_taken++;
      end
   end

   // event transfers are checked against the oldest prediction
   always @(posedge clock) begin : note_monitor
      note_event_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (note_q.size() == 0) begin
            report_mismatch($sformatf("event %0d arrived with none expected", events_seen));
         end else begin
            want = note_q.pop_front();
            check_field("note", rsp_ch.note, want.note);
            check_field("note_on", rsp_ch.note_on, want.note_on);
            check_field("velocity", rsp_ch.velocity, want.velocity);
            check_field("channel", rsp_ch.channel, want.channel);
            check_field("last", rsp_ch.last, want.last);
         end
         events_seen++;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", quiet_cycles);
            $display("[key_matrix_debounce_note_events] ERROR");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DEBOUNCE_TIME:  cfg_debounce = value;
         CSR_BASE_NOTE:      cfg_base     = value[NOTE_W-1:0];
         CSR_PRESS_VELOCITY: cfg_velocity = value[VEL_W-1:0];
         CSR_MIDI_CHANNEL:   cfg_channel  = value[CHAN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(int debounce, int base, int velocity, int channel);
      write_reg(CSR_DEBOUNCE_TIME, CSR_DATA_W'(debounce));
      write_reg(CSR_BASE_NOTE, CSR_DATA_W'(base));
      write_reg(CSR_PRESS_VELOCITY, CSR_DATA_W'(velocity));
      write_reg(CSR_MIDI_CHANNEL, CSR_DATA_W'(channel));
      settings_used++;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   task automatic push_scan(int row, int cols, logic [TIME_W-1:0] now);
      row_scan_type item;
      item.row  = ROW_W'(row);
      item.cols = IN_COLS'(cols);
      item.now  = now;
      scan_q.push_back(item);
   endtask

   // wait for every row to go out and every event to come back, then let the pipe settle
   task automatic wait_idle();
      while (scan_q.size() != 0 || req_ch.valid || note_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly sequential row scans with held keys, bounces and occasional noise
   task automatic gen_scans(int count);
      int                 step_max;
      logic [ROW_W-1:0]   row;
      logic [IN_COLS-1:0] cols;
      step_max = int'(cfg_debounce) / 8 + 2;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 80) begin
            row = scan_row;
            scan_row = scan_row + 1'b1;
         end else begin
            row = ROW_W'($urandom_range(NUM_ROWS - 1));
         end
         if ($urandom_range(99) < 8)
            row_target[row] = row_target[row] ^ IN_COLS'(1 << $urandom_range(IN_COLS - 1));
         cols = row_target[row];
         if ($urandom_range(99) < 10)
            cols = cols ^ IN_COLS'($urandom_range(15));
         if ($urandom_range(99) < 3)
            cols = IN_COLS'($urandom_range(15));
         scan_now = scan_now + TIME_W'($urandom_range(step_max));
         if ($urandom_range(99) < 2)
            scan_now = scan_now + $urandom;
         push_scan(row, cols, scan_now);
      end
   endtask

   // whole-row presses and releases that keep every lane confirming
   task automatic push_burst(int count);
      for (int k = 0; k < count; k++) begin
         scan_now = scan_now + 2;
         push_scan(k % NUM_ROWS, ((k / 8) % 2) ? 4'hF : 4'h0, scan_now);
      end
   endtask

   initial begin : stimulus
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_DEBOUNCE_TIME;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.row         = '0;
      req_ch.col_pressed = '0;
      req_ch.now_ms      = '0;
      rsp_ch.ready       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full-row press and release, short hold, bounce, timer wrap
      set_idling(0, 0);
      push_scan(0, 4'h0, 32'd0);
      push_scan(0, 4'hF, 32'd1);
      push_scan(0, 4'hF, 32'd5);
      push_scan(0, 4'hF, 32'd6);
      push_scan(0, 4'h0, 32'd7);
      push_scan(0, 4'h0, 32'd12);
      push_scan(3, 4'hF, 32'd20);
      push_scan(3, 4'hF, 32'd25);
      push_scan(3, 4'h0, 32'd26);
      push_scan(3, 4'h5, 32'd27);
      push_scan(3, 4'h5, 32'd31);
      push_scan(1, 4'h9, 32'hFFFF_FFFD);
      push_scan(1, 4'h9, 32'h0000_0002);
      push_scan(2, 4'h6, 32'h0000_0010);
      push_scan(2, 4'h6, 32'hFFFF_FFFF);
      push_scan(1, 4'h0, 32'h8000_0000);
      push_scan(1, 4'h0, 32'h8000_0004);
      push_scan(1, 4'h0, 32'h8000_0005);
      wait_idle();

      // zero debounce and saturated notes, sender idling
      set_config(0, NOTE_MAX, NOTE_MAX, 16);
      push_scan(2, 4'hF, 32'd100);
      push_scan(2, 4'hF, 32'd100);
      push_scan(0, 4'hA, 32'd101);
      push_scan(0, 4'hA, 32'd101);
      scan_now = 32'd200;
      set_idling(77, 0);
      gen_scans(90);
      wait_idle();

      // longest debounce, lowest note, receiver stalling
      set_config(255, 0, 1, 1);
      set_idling(0, 77);
      gen_scans(90);
      wait_idle();

      // zero velocity and channel zero, partial saturation, both sides idling
      set_config($urandom_range(1, 40), 120, 0, 0);
      set_idling(38, 38);
      gen_scans(90);
      wait_idle();

      // out-of-range channel; receiver holds off while the sender keeps offering rows
      set_config(5, $urandom_range(0, NOTE_MAX), $urandom_range(1, NOTE_MAX), 31);
      set_idling(0, 0);
      hold_requests++;
      push_burst(48);
      wait_idle();
      gen_scans(60);
      wait_idle();

      // random settings across a timestamp wrap, both sides idling
      set_config($urandom_range(99) < 70 ? $urandom_range(0, 12) : $urandom_range(0, 255),
                 $urandom_range(0, NOTE_MAX), $urandom_range(1, NOTE_MAX),
                 $urandom_range(1, 16));
      scan_now = 32'hFFFF_FF80;
      set_idling(38, 38);
      gen_scans(90);
      wait_idle();

      if (note_q.size() != 0)
         report_mismatch($sformatf("%0d note events never arrived", note_q.size()));
      $display("covered %0d scanned rows and %0d note events over %0d register settings",
               rows_taken, events_seen, settings_used);
      $display("including zero and longest debounce, saturated notes and timestamp wrap");
      if (err_count == 0) begin
         $display("[key_matrix_debounce_note_events] OK");
      end else begin
         $display("%0d mismatches", err_count);
         $display("[key_matrix_debounce_note_events] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/kmd_pkg.sv
hw/rtl/kmd_if.sv
hw/rtl/kmd_lane.sv
hw/rtl/kmd_merge.sv
hw/rtl/key_matrix_debounce_note_events.sv
tb/sv/tb_key_matrix_debounce_note_events.sv
